// ----- rtl/tcc_pkg.sv -----
package tcc_pkg;

    // Coordinate width of the vertex fields
    localparam int COORD_BITS = 16;
    // Default number of fraction bits in the results
    localparam int FRAC_BITS_DEFAULT = 8;
    // Width of every fixed-point result field
    localparam int OUT_BITS = 24;
    // Vertex count that the centroid divides by
    localparam int CENTROID_DIV = 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_coord;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
    } tri_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] incenter_x;
        logic signed [OUT_BITS-1:0] incenter_y;
        logic signed [OUT_BITS-1:0] centroid_x;
        logic signed [OUT_BITS-1:0] centroid_y;
        logic                       degenerate;
    } ctr_t;

endpackage

// ----- rtl/tcc_sqrt_stage.sv -----
module tcc_sqrt_stage #(
    parameter int SW     = 25,
    parameter int LANES  = 3,
    parameter int SIDE_W = 96
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [LANES-1:0][2*SW-1:0]    in_rad,
    input  logic [LANES-1:0][SW-1:0]      in_rem,
    input  logic [LANES-1:0][SW-1:0]      in_root,
    input  logic [SIDE_W-1:0]             in_side,
    output logic                          out_valid,
    output logic [LANES-1:0][2*SW-1:0]    out_rad,
    output logic [LANES-1:0][SW-1:0]      out_rem,
    output logic [LANES-1:0][SW-1:0]      out_root,
    output logic [SIDE_W-1:0]             out_side
);

    logic                          valid_reg;
    logic [LANES-1:0][2*SW-1:0]    rad_reg, rad_next;
    logic [LANES-1:0][SW-1:0]      rem_reg, rem_next;
    logic [LANES-1:0][SW-1:0]      root_reg, root_next;
    logic [SIDE_W-1:0]             side_reg;
    logic [LANES-1:0][SW+1:0]      part;
    logic [LANES-1:0][SW+1:0]      trial;

    // Resolve one root bit per lane: bring down two radicand bits, try 4q+1
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            part[l]     = {in_rem[l], in_rad[l][2*SW-1 -: 2]};
            trial[l]    = {in_root[l], 2'b01};
            rad_next[l] = {in_rad[l][2*SW-3:0], 2'b00};
            if (part[l] >= trial[l])
            begin
                rem_next[l]  = SW'(part[l] - trial[l]);
                root_next[l] = {in_root[l][SW-2:0], 1'b1};
            end
            else
            begin
                rem_next[l]  = SW'(part[l]);
                root_next[l] = {in_root[l][SW-2:0], 1'b0};
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/tcc_div_stage.sv -----
module tcc_div_stage #(
    parameter int LANES  = 4,
    parameter int DW     = 27,
    parameter int QB     = 24,
    parameter int SIDE_W = 37
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [LANES-1:0][DW-1:0]  in_den,
    input  logic [LANES-1:0][DW-1:0]  in_rem,
    input  logic [LANES-1:0][QB-1:0]  in_quo,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [LANES-1:0][DW-1:0]  out_den,
    output logic [LANES-1:0][DW-1:0]  out_rem,
    output logic [LANES-1:0][QB-1:0]  out_quo,
    output logic [SIDE_W-1:0]         out_side
);

    logic                      valid_reg;
    logic [LANES-1:0][DW-1:0]  den_reg;
    logic [LANES-1:0][DW-1:0]  rem_reg, rem_next;
    logic [LANES-1:0][QB-1:0]  quo_reg, quo_next;
    logic [SIDE_W-1:0]         side_reg;
    logic [LANES-1:0][DW:0]    part;

    // Restoring step: shift in the next dividend bit, subtract when it fits.
    // Quotient bits fill the dividend word from the bottom as it empties.
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            part[l] = {in_rem[l], in_quo[l][QB-1]};
            if (part[l] >= {1'b0, in_den[l]})
            begin
                rem_next[l] = DW'(part[l] - {1'b0, in_den[l]});
                quo_next[l] = {in_quo[l][QB-2:0], 1'b1};
            end
            else
            begin
                rem_next[l] = DW'(part[l]);
                quo_next[l] = {in_quo[l][QB-2:0], 1'b0};
            end
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Advance the payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= in_den;
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_den   = den_reg;
    assign out_rem   = rem_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/triangle_center_calc.sv -----
// Incenter and centroid of one triangle per transaction. The block is a
// pipeline that takes a new triangle in every cycle unless tri_stall is
// high, and returns results in input order. Its depth is set by the
// square root, which resolves one root bit per stage, and the incenter
// divider, which resolves one quotient bit per stage. The centroid divides
// by three with a reciprocal multiply and rides alongside the divider.
// A skid register behind the output lets one more transaction leave the
// pipeline while the output is stalled; tri_stall rises only once that
// register is holding.
// All three vertices coinciding sets degenerate and returns vertex A as the incenter.
module triangle_center_calc #(
    parameter int FRAC_BITS = tcc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tri_valid,
    output logic          tri_stall,
    input  tcc_pkg::tri_t tri_data,
    output logic          ctr_valid,
    input  logic          ctr_stall,
    output tcc_pkg::ctr_t ctr_data
);

    import tcc_pkg::*;

    localparam int CB    = COORD_BITS;
    localparam int FB    = FRAC_BITS;
    localparam int D2W   = 2 * CB + 1;
    localparam int SW    = CB + FB + 1;
    localparam int RADW  = 2 * SW;
    localparam int PW    = SW + CB + 1;
    localparam int NW    = PW + 2;
    localparam int NSW   = NW + FB;
    localparam int DW    = SW + 2;
    localparam int QB    = CB + FB;
    localparam int CSW   = CB + 2;
    localparam int GSW   = CSW + FB;
    localparam int GPW   = 2 * GSW;
    localparam int TRI_W = $bits(tri_t);
    localparam int EW    = ((QB + 1 > OUT_BITS) ? QB + 1 : OUT_BITS) + 1;
    localparam logic signed [EW-1:0] SAT_HI =
        EW'((64'sd1 <<< (OUT_BITS - 1)) - 64'sd1);
    localparam logic signed [EW-1:0] SAT_LO = ~SAT_HI;
    // Reciprocal of the vertex count, rounded up, scaled by 2^GSW
    localparam logic [GSW-1:0] RCP3 =
        GSW'(((64'd1 << GSW) + 64'(CENTROID_DIV) - 64'd1) / 64'(CENTROID_DIV));

    typedef struct packed {
        logic [3:0]           neg;
        logic                 degen;
        logic [1:0][QB-1:0]   gq;
        logic signed [CB-1:0] ax;
        logic signed [CB-1:0] ay;
    } dside_t;

    localparam int DSIDE_W = $bits(dside_t);

    function automatic logic [CB-1:0] absdiff(input logic signed [CB-1:0] p,
                                              input logic signed [CB-1:0] q);
        logic signed [CB:0] d;
        d = (CB+1)'(p) - (CB+1)'(q);
        return d[CB] ? CB'(-d) : CB'(d);
    endfunction

    function automatic logic [OUT_BITS-1:0] sat(input logic signed [QB:0] v);
        logic signed [EW-1:0] w;
        w = EW'(v);
        if (w > SAT_HI)
        begin
            w = SAT_HI;
        end
        else if (w < SAT_LO)
        begin
            w = SAT_LO;
        end
        return OUT_BITS'(w);
    endfunction

    logic en;

    // ---------------- stage 1: absolute coordinate differences
    logic               s1_v_reg;
    tri_t               s1_tri_reg;
    logic [5:0][CB-1:0] s1_d_reg, s1_d_next;

    // Sides: a = BC, b = CA, c = AB
    always_comb
    begin
        s1_d_next[0] = absdiff(tri_data.bx, tri_data.cx);
        s1_d_next[1] = absdiff(tri_data.by_coord, tri_data.cy);
        s1_d_next[2] = absdiff(tri_data.cx, tri_data.ax);
        s1_d_next[3] = absdiff(tri_data.cy, tri_data.ay);
        s1_d_next[4] = absdiff(tri_data.ax, tri_data.bx);
        s1_d_next[5] = absdiff(tri_data.ay, tri_data.by_coord);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= tri_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_tri_reg <= tri_data;
            s1_d_reg   <= s1_d_next;
        end
    end

    // ---------------- stage 2: squared side lengths, scaled radicands
    logic                 s2_v_reg;
    tri_t                 s2_tri_reg;
    logic [2:0][RADW-1:0] s2_rad_reg, s2_rad_next;
    logic [2:0][2*CB-1:0] sqx, sqy;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            sqx[l]         = s1_d_reg[2*l] * s1_d_reg[2*l];
            sqy[l]         = s1_d_reg[2*l+1] * s1_d_reg[2*l+1];
            s2_rad_next[l] = RADW'(D2W'(sqx[l]) + D2W'(sqy[l])) << (2 * FB);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_tri_reg <= s1_tri_reg;
            s2_rad_reg <= s2_rad_next;
        end
    end

    // ---------------- square root chain, one root bit per stage
    logic                 sq_v    [0:SW];
    logic [2:0][RADW-1:0] sq_rad  [0:SW];
    logic [2:0][SW-1:0]   sq_rem  [0:SW];
    logic [2:0][SW-1:0]   sq_root [0:SW];
    logic [TRI_W-1:0]     sq_side [0:SW];

    assign sq_v[0]    = s2_v_reg;
    assign sq_rad[0]  = s2_rad_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_side[0] = s2_tri_reg;

    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        tcc_sqrt_stage #(
            .SW     (SW),
            .LANES  (3),
            .SIDE_W (TRI_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (sq_v[i]),
            .in_rad    (sq_rad[i]),
            .in_rem    (sq_rem[i]),
            .in_root   (sq_root[i]),
            .in_side   (sq_side[i]),
            .out_valid (sq_v[i+1]),
            .out_rad   (sq_rad[i+1]),
            .out_rem   (sq_rem[i+1]),
            .out_root  (sq_root[i+1]),
            .out_side  (sq_side[i+1])
        );
    end

    // ---------------- stage P: weighted products, side sum, vertex sums
    tri_t                        pt;
    logic                        sp_v_reg;
    logic signed [5:0][PW-1:0]   sp_pr_reg, sp_pr_next;
    logic [DW-1:0]               sp_den_reg, sp_den_next;
    logic signed [CSW-1:0]       sp_gx_reg, sp_gx_next;
    logic signed [CSW-1:0]       sp_gy_reg, sp_gy_next;
    logic signed [CB-1:0]        sp_ax_reg, sp_ay_reg;
    logic signed [2:0][SW:0]     sw;

    always_comb
    begin
        pt = tri_t'(sq_side[SW]);
        for (int l = 0; l < 3; l++)
        begin
            sw[l] = $signed({1'b0, sq_root[SW][l]});
        end
        sp_pr_next[0] = PW'(sw[0]) * PW'(pt.ax);
        sp_pr_next[1] = PW'(sw[1]) * PW'(pt.bx);
        sp_pr_next[2] = PW'(sw[2]) * PW'(pt.cx);
        sp_pr_next[3] = PW'(sw[0]) * PW'(pt.ay);
        sp_pr_next[4] = PW'(sw[1]) * PW'(pt.by_coord);
        sp_pr_next[5] = PW'(sw[2]) * PW'(pt.cy);
        sp_den_next   = DW'(sq_root[SW][0]) + DW'(sq_root[SW][1])
                      + DW'(sq_root[SW][2]);
        sp_gx_next    = CSW'(pt.ax) + CSW'(pt.bx) + CSW'(pt.cx);
        sp_gy_next    = CSW'(pt.ay) + CSW'(pt.by_coord) + CSW'(pt.cy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sp_v_reg <= sq_v[SW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sp_pr_reg  <= sp_pr_next;
            sp_den_reg <= sp_den_next;
            sp_gx_reg  <= sp_gx_next;
            sp_gy_reg  <= sp_gy_next;
            sp_ax_reg  <= pt.ax;
            sp_ay_reg  <= pt.ay;
        end
    end

    // ---------------- stage Q: numerators, signs, magnitudes, centroid
    logic signed [NW-1:0]    nx, ny;
    logic signed [NSW-1:0]   nxs, nys;
    logic signed [GSW-1:0]   gxs, gys;
    logic [1:0][NSW-1:0]     mag;
    logic [1:0][GSW-1:0]     gmag;
    logic [1:0][GPW-1:0]     gprod;
    dside_t                  qside;
    logic                    sq_q_v_reg;
    logic [1:0][DW-1:0]      sq_q_den_reg, sq_q_den_next;
    logic [1:0][DW-1:0]      sq_q_rem_reg, sq_q_rem_next;
    logic [1:0][QB-1:0]      sq_q_quo_reg, sq_q_quo_next;
    logic [DSIDE_W-1:0]      sq_q_side_reg;

    always_comb
    begin
        nx  = NW'($signed(sp_pr_reg[0])) + NW'($signed(sp_pr_reg[1]))
            + NW'($signed(sp_pr_reg[2]));
        ny  = NW'($signed(sp_pr_reg[3])) + NW'($signed(sp_pr_reg[4]))
            + NW'($signed(sp_pr_reg[5]));
        nxs = NSW'(nx) <<< FB;
        nys = NSW'(ny) <<< FB;
        gxs = GSW'(sp_gx_reg) <<< FB;
        gys = GSW'(sp_gy_reg) <<< FB;
        mag[0]  = nxs[NSW-1] ? NSW'(-nxs) : NSW'(nxs);
        mag[1]  = nys[NSW-1] ? NSW'(-nys) : NSW'(nys);
        gmag[0] = gxs[GSW-1] ? GSW'(-gxs) : GSW'(gxs);
        gmag[1] = gys[GSW-1] ? GSW'(-gys) : GSW'(gys);
        // Divide the vertex sums by three: multiply by the reciprocal
        for (int l = 0; l < 2; l++)
        begin
            gprod[l]    = GPW'(gmag[l]) * GPW'(RCP3);
            qside.gq[l] = QB'(gprod[l] >> GSW);
        end
        qside.neg   = {gys[GSW-1], gxs[GSW-1], nys[NSW-1], nxs[NSW-1]};
        qside.degen = (sp_den_reg == '0);
        qside.ax    = sp_ax_reg;
        qside.ay    = sp_ay_reg;
        for (int l = 0; l < 2; l++)
        begin
            sq_q_den_next[l] = sp_den_reg;
            sq_q_rem_next[l] = DW'(mag[l] >> QB);
            sq_q_quo_next[l] = mag[l][QB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_q_v_reg <= 1'b0;
        end
        else if (en)
        begin
            sq_q_v_reg <= sp_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_q_den_reg  <= sq_q_den_next;
            sq_q_rem_reg  <= sq_q_rem_next;
            sq_q_quo_reg  <= sq_q_quo_next;
            sq_q_side_reg <= qside;
        end
    end

    // ---------------- incenter divider chain, one quotient bit per stage
    logic                 dv_v    [0:QB];
    logic [1:0][DW-1:0]   dv_den  [0:QB];
    logic [1:0][DW-1:0]   dv_rem  [0:QB];
    logic [1:0][QB-1:0]   dv_quo  [0:QB];
    logic [DSIDE_W-1:0]   dv_side [0:QB];

    assign dv_v[0]    = sq_q_v_reg;
    assign dv_den[0]  = sq_q_den_reg;
    assign dv_rem[0]  = sq_q_rem_reg;
    assign dv_quo[0]  = sq_q_quo_reg;
    assign dv_side[0] = sq_q_side_reg;

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        tcc_div_stage #(
            .LANES  (2),
            .DW     (DW),
            .QB     (QB),
            .SIDE_W (DSIDE_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (dv_v[i]),
            .in_den    (dv_den[i]),
            .in_rem    (dv_rem[i]),
            .in_quo    (dv_quo[i]),
            .in_side   (dv_side[i]),
            .out_valid (dv_v[i+1]),
            .out_den   (dv_den[i+1]),
            .out_rem   (dv_rem[i+1]),
            .out_quo   (dv_quo[i+1]),
            .out_side  (dv_side[i+1])
        );
    end

    // ---------------- final stage: restore signs, saturate, pick incenter
    dside_t                   fs;
    logic signed [3:0][QB:0]  qs;
    logic signed [QB:0]       axs, ays;
    logic                     tl_v_reg;
    ctr_t                     tl_d_reg, tl_d_next;

    always_comb
    begin
        fs = dside_t'(dv_side[QB]);
        qs[0] = $signed({1'b0, dv_quo[QB][0]});
        qs[1] = $signed({1'b0, dv_quo[QB][1]});
        qs[2] = $signed({1'b0, fs.gq[0]});
        qs[3] = $signed({1'b0, fs.gq[1]});
        for (int l = 0; l < 4; l++)
        begin
            if (fs.neg[l])
            begin
                qs[l] = -qs[l];
            end
        end
        axs = (QB+1)'(fs.ax) <<< FB;
        ays = (QB+1)'(fs.ay) <<< FB;
        tl_d_next.incenter_x = fs.degen ? sat(axs) : sat(qs[0]);
        tl_d_next.incenter_y = fs.degen ? sat(ays) : sat(qs[1]);
        tl_d_next.centroid_x = sat(qs[2]);
        tl_d_next.centroid_y = sat(qs[3]);
        tl_d_next.degenerate = fs.degen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_v_reg <= 1'b0;
        end
        else if (en)
        begin
            tl_v_reg <= dv_v[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tl_d_reg <= tl_d_next;
        end
    end

    // ---------------- output register and skid register
    logic ctr_v_reg, ctr_v_next;
    ctr_t ctr_d_reg, ctr_d_next;
    logic skid_v_reg, skid_v_next;
    ctr_t skid_d_reg, skid_d_next;
    logic out_free;

    // Advance the pipeline whenever the skid register is empty
    assign en       = !skid_v_reg;
    assign out_free = !ctr_v_reg || !ctr_stall;

    // Drain the pipeline tail or the skid into the output, or park the tail in the skid
    always_comb
    begin
        ctr_v_next  = ctr_v_reg;
        ctr_d_next  = ctr_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (en)
        begin
            if (out_free)
            begin
                ctr_v_next = tl_v_reg;
                ctr_d_next = tl_d_reg;
            end
            else if (tl_v_reg)
            begin
                skid_v_next = 1'b1;
                skid_d_next = tl_d_reg;
            end
        end
        else if (out_free)
        begin
            ctr_v_next  = 1'b1;
            ctr_d_next  = skid_d_reg;
            skid_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            ctr_v_reg  <= ctr_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctr_d_reg  <= ctr_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign tri_stall = skid_v_reg;
    assign ctr_valid = ctr_v_reg;
    assign ctr_data  = ctr_d_reg;

`ifndef SYNTHESIS
    // A parked transaction implies the output register is occupied
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> ctr_v_reg)
        else $error("skid register holds a transaction with the output empty");

    // The skid register only fills while the output is stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(ctr_v_reg && ctr_stall))
        else $error("skid register filled without an output stall");

    // Coincident vertices give identical incenter and centroid
    a_degen_match: assert property (@(posedge clk) disable iff (!rst_n)
        (ctr_v_reg && ctr_d_reg.degenerate) |->
        (ctr_d_reg.incenter_x == ctr_d_reg.centroid_x &&
         ctr_d_reg.incenter_y == ctr_d_reg.centroid_y))
        else $error("degenerate triangle with incenter off the centroid");
`endif

endmodule

// ----- tb/triangle_center_calc_check.sv -----
`timescale 1ns / 100ps

module triangle_center_calc_check (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tri_valid,
    input  logic          tri_stall,
    input  tcc_pkg::tri_t tri_data,
    input  logic          ctr_valid,
    input  logic          ctr_stall,
    input  tcc_pkg::ctr_t ctr_data,
    output int            errors,
    output int            pending,
    output int            n_degen
);

    import tcc_pkg::*;

    localparam int FB = FRAC_BITS_DEFAULT;

    ctr_t centre_q[$];

    // Integer square root of a 64-bit value, one result bit per pass
    function automatic longint unsigned root_of(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint side_of(longint x0, longint y0, longint x1, longint y1);
        longint unsigned dx;
        longint unsigned dy;
        dx = (x0 >= x1) ? x0 - x1 : x1 - x0;
        dy = (y0 >= y1) ? y0 - y1 : y1 - y0;
        return longint'(root_of((dx * dx + dy * dy) << (2 * FB)));
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(longint v);
        longint hi;
        hi = (longint'(1) << (OUT_BITS - 1)) - 1;
        if (v > hi)
            v = hi;
        if (v < -hi - 1)
            v = -hi - 1;
        return v[OUT_BITS-1:0];
    endfunction

    // Work out incenter and centroid of one triangle
    function automatic ctr_t centres_of(tri_t t);
        ctr_t   r;
        longint ax, ay, bx, by, cx, cy, sa, sb, sc, den;
        ax = t.ax; ay = t.ay; bx = t.bx; by = t.by_coord; cx = t.cx; cy = t.cy;
        sa = side_of(bx, by, cx, cy);
        sb = side_of(ax, ay, cx, cy);
        sc = side_of(ax, ay, bx, by);
        den = sa + sb + sc;
        r.degenerate = (den == 0);
        if (r.degenerate)
        begin
            r.incenter_x = clamp_out(ax <<< FB);
            r.incenter_y = clamp_out(ay <<< FB);
        end
        else
        begin
            r.incenter_x = clamp_out(((sa * ax + sb * bx + sc * cx) <<< FB) / den);
            r.incenter_y = clamp_out(((sa * ay + sb * by + sc * cy) <<< FB) / den);
        end
        r.centroid_x = clamp_out(((ax + bx + cx) <<< FB) / CENTROID_DIV);
        r.centroid_y = clamp_out(((ay + by + cy) <<< FB) / CENTROID_DIV);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        n_degen = 0;
        pending = 0;
    end

    // Predict on input transactions, compare on output transactions
    always @(posedge clk)
    begin
        ctr_t w;
        if (rst_n && tri_valid && !tri_stall)
            centre_q = {centre_q, centres_of(tri_data)};
        if (rst_n && ctr_valid && !ctr_stall)
        begin
            if (centre_q.size() == 0)
                report_mismatch("unexpected transaction", 0, 0);
            else
            begin
                w = centre_q.pop_front();
                if (w.degenerate)
                    n_degen++;
                if (ctr_data.incenter_x !== w.incenter_x)
                    report_mismatch("incenter_x", ctr_data.incenter_x, w.incenter_x);
                if (ctr_data.incenter_y !== w.incenter_y)
                    report_mismatch("incenter_y", ctr_data.incenter_y, w.incenter_y);
                if (ctr_data.centroid_x !== w.centroid_x)
                    report_mismatch("centroid_x", ctr_data.centroid_x, w.centroid_x);
                if (ctr_data.centroid_y !== w.centroid_y)
                    report_mismatch("centroid_y", ctr_data.centroid_y, w.centroid_y);
                if (ctr_data.degenerate !== w.degenerate)
                    report_mismatch("degenerate", ctr_data.degenerate, w.degenerate);
            end
        end
        pending = centre_q.size();
    end

endmodule

// ----- tb/triangle_center_calc_test.sv -----
`timescale 1ns / 100ps

module triangle_center_calc_test;
    import tcc_pkg::*;

    localparam int LATENCY = 55;
    localparam int N_RANDOM = 930;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 0;
    logic rst_n = 0;
    logic tri_valid = 0;
    logic tri_stall;
    tri_t tri_data = '0;
    logic ctr_valid;
    logic ctr_stall = 0;
    ctr_t ctr_data;
    int   errors, pending, n_degen;
    int   n_sent;
    longint cycles;
    bit   hold_request = 0;

    always #5 clk = ~clk;

    triangle_center_calc dut (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
        .ctr_valid(ctr_valid), .ctr_stall(ctr_stall), .ctr_data(ctr_data)
    );

    triangle_center_calc_check check (
        .clk(clk), .rst_n(rst_n),
        .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
        .ctr_valid(ctr_valid), .ctr_stall(ctr_stall), .ctr_data(ctr_data),
        .errors(errors), .pending(pending), .n_degen(n_degen)
    );

    function automatic int gap_len();
        return ($urandom_range(0, 9) < 7) ? 0 :
               ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one triangle and hold it until taken; drop valid only for a gap
    task automatic send(tri_t t);
        int g;
        g = gap_len();
        if (g != 0)
        begin
            tri_valid <= 0;
            repeat (g) @(negedge clk);
        end
        tri_data <= t;
        tri_valid <= 1;
        @(posedge clk);
        while (tri_stall)
            @(posedge clk);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic tri_t mk(int ax, int ay, int bx, int by, int cx, int cy);
        tri_t t;
        t.ax = 16'(ax); t.ay = 16'(ay); t.bx = 16'(bx);
        t.by_coord = 16'(by); t.cx = 16'(cx); t.cy = 16'(cy);
        return t;
    endfunction

    // Receiver stall: random gaps, plus one long hold-off on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                ctr_stall <= 1;
                repeat (200) @(negedge clk);
                ctr_stall <= 0;
                hold_request = 0;
            end
            else
            begin
                g = gap_len();
                if (g != 0)
                begin
                    ctr_stall <= 1;
                    repeat (g) @(negedge clk);
                    ctr_stall <= 0;
                end
            end
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("triangle_center_calc_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        tri_t t;
        int   v;
        cycles = 0;
        n_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: extremes, coincident vertices, collinear and plain triangles
        send(mk(0, 0, 0, 0, 0, 0));
        send(mk(-32768, -32768, -32768, -32768, -32768, -32768));
        send(mk(32767, 32767, 32767, 32767, 32767, 32767));
        send(mk(123, -45, 123, -45, 123, -45));
        send(mk(-32768, -32768, 32767, 32767, -32768, 32767));
        send(mk(32767, -32768, -32768, 32767, 32767, 32767));
        send(mk(0, 0, 3, 0, 0, 4));
        send(mk(0, 0, 1, 0, 2, 0));
        send(mk(5, 5, 5, 5, 9, 9));
        send(mk(-1, -1, 0, 0, 0, 1));
        send(mk(-32768, 0, 32767, 0, 0, 0));
        send(mk(1, 1, 1, 1, 1, 2));
        send(mk(-32768, -32768, -32768, -32768, 32767, 32767));
        send(mk(-1, 0, 0, 0, 0, 0));
        send(mk(16'h5555, 16'haaaa, 16'haaaa, 16'h5555, 16'hffff, 16'h0001));

        // Random triangles; a long receiver hold-off part way through
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == 300)
                hold_request = 1;
            v = $urandom_range(0, 19);
            if (v == 0)
            begin
                t.ax = coord(); t.ay = coord();
                t.bx = t.ax; t.by_coord = t.ay; t.cx = t.ax; t.cy = t.ay;
            end
            else
            begin
                t.ax = coord(); t.ay = coord(); t.bx = coord();
                t.by_coord = coord(); t.cx = coord(); t.cy = coord();
                if (v == 1)
                begin
                    t.bx = t.ax; t.by_coord = t.ay;
                end
            end
            send(t);
        end
        tri_valid <= 0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d triangles, %0d of them with coincident vertices,", n_sent, n_degen);
        $display("with random gaps on both sides and one long output hold-off.");
        if (errors == 0)
            $display("triangle_center_calc_test: done, clean");
        else
            $display("triangle_center_calc_test: done, errors");
        $finish;
    end

endmodule

// ----- triangle_center_calc.f -----
rtl/tcc_pkg.sv
rtl/tcc_sqrt_stage.sv
rtl/tcc_div_stage.sv
rtl/triangle_center_calc.sv
tb/triangle_center_calc_check.sv
tb/triangle_center_calc_test.sv
